/* rtl/smk_pkg.sv */
// ----------------------------------------------------------------------------
// smk_pkg: shared types for the sorted multiset block
// Action and status codes and the sequencer states.
// ----------------------------------------------------------------------------
package smk_pkg;

   localparam int unsigned KEY_W    = 32;
   localparam int unsigned RANK_W   = 9;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_ERASE  = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_RANK = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_ERS_RD,
      ST_ERS_CMP,
      ST_QRY_RD,
      ST_QRY_CMP
   } state_type;

endpackage

/* rtl/smk_ram.sv */
// ----------------------------------------------------------------------------
// smk_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smk_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sorted_multiset_kth_largest_top.sv */
// ----------------------------------------------------------------------------
// sorted_multiset_kth_largest_top: bounded multiset kept in descending order
// A query reads one entry; an insert walks down from the tail to its slot;
//   an erase walks every entry. A full insert, a bad rank or an unused action
//   answers straight from idle. Throughput: one item at a time; busy stays
//   high while the single RAM read port and the shared compare unit walk the entries.
// Reset (synchronous, active high) empties the store; entry contents are not
//   cleared. The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_multiset_kth_largest_top
   import smk_pkg::*;
#(
   parameter int unsigned CAPACITY = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic signed [KEY_W-1:0]    req_key_value,
   input  logic [RANK_W-1:0]          req_rank,
   output logic                       rsp_valid,
   output logic signed [KEY_W-1:0]    rsp_result_value,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   // Sequencer and control registers
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;     // insert: slot to fill; erase: read pointer
   logic [CNT_W-1:0]   wr_ff, wr_in;       // erase: compaction write pointer
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_W-1:0] rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;

   // RAM port signals
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [KEY_W-1:0]   ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [KEY_W-1:0]   ram_rd_data;

   // Shared compare unit: stored entry against the held key
   logic               cmp_ge;
   logic               cmp_eq;
   assign cmp_ge = $signed(ram_rd_data) >= key_ff;
   assign cmp_eq = ram_rd_data == key_ff;

   logic               accept;
   logic               store_full;
   logic               rank_bad;
   logic [CMP_W-1:0]   rank_ext;
   logic [CMP_W-1:0]   count_ext;
   logic [CMP_W-1:0]   rank_dec;
   logic [CNT_W-1:0]   ptr_dec;
   logic [CNT_W-1:0]   ptr_inc;
   logic [CNT_W-1:0]   wr_inc;
   action_type         req_act;

   assign accept     = start && !busy;
   assign req_act    = action_type'(req_action);
   assign store_full = count_ff == CNT_W'(CAPACITY);
   assign rank_ext   = CMP_W'(req_rank);
   assign count_ext  = CMP_W'(count_ff);
   assign rank_dec   = rank_ext - CMP_W'(1);
   assign rank_bad   = (req_rank == '0) || (rank_ext > count_ext);
   assign ptr_dec    = ptr_ff - CNT_W'(1);
   assign ptr_inc    = ptr_ff + CNT_W'(1);
   assign wr_inc     = wr_ff + CNT_W'(1);

   assign busy = state_ff != ST_IDLE;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_act)
                  ACT_INSERT: state_in = store_full ? ST_IDLE : ST_INS_RD;
                  ACT_ERASE:  state_in = ST_ERS_RD;
                  ACT_QUERY:  state_in = rank_bad ? ST_IDLE : ST_QRY_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_RD:  state_in = (ptr_ff == '0) ? ST_IDLE : ST_INS_CMP;
         ST_INS_CMP: state_in = cmp_ge ? ST_IDLE : ST_INS_RD;
         ST_ERS_RD:  state_in = (ptr_ff == count_ff) ? ST_IDLE : ST_ERS_CMP;
         ST_ERS_CMP: state_in = ST_ERS_RD;
         ST_QRY_RD:  state_in = ST_QRY_CMP;
         ST_QRY_CMP: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath, RAM control and result
   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      wr_in         = wr_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STAT_OK;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ptr_ff[IDX_W-1:0];
      ram_wr_data   = key_ff;
      ram_rd_addr   = ptr_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in = req_key_value;
               case (req_act)
                  ACT_INSERT: begin
                     // Walk down from the tail, shifting smaller entries up.
                     ptr_in = count_ff;
                     if (store_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_FULL;
                     end
                  end
                  ACT_ERASE: begin
                     ptr_in = '0;
                     wr_in  = '0;
                  end
                  ACT_QUERY: begin
                     ptr_in = CNT_W'(rank_dec);
                     if (rank_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_RANK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_INS_RD: begin
            ram_rd_addr = ptr_dec[IDX_W-1:0];
            if (ptr_ff == '0) begin
               // Every held entry was smaller: new value goes to the head.
               ram_wr_en    = 1'b1;
               count_in     = count_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
            end
         end
         ST_INS_CMP: begin
            ram_wr_en = 1'b1;
            if (cmp_ge) begin
               // Land after any equal copies.
               count_in     = count_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
            end else begin
               ram_wr_data = ram_rd_data;
               ptr_in      = ptr_dec;
            end
         end
         ST_ERS_RD: begin
            if (ptr_ff == count_ff) begin
               count_in     = wr_ff;
               rsp_valid_in = 1'b1;
            end
         end
         ST_ERS_CMP: begin
            ram_wr_addr = wr_ff[IDX_W-1:0];
            ram_wr_data = ram_rd_data;
            if (!cmp_eq) begin
               // Keep this entry: compact it down to the write pointer.
               ram_wr_en = 1'b1;
               wr_in     = wr_inc;
            end
            ptr_in = ptr_inc;
         end
         ST_QRY_RD: begin
            // Hold the address while the RAM read completes.
         end
         ST_QRY_CMP: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = $signed(ram_rd_data);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      wr_ff         <= wr_in;
      key_ff        <= key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   smk_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   // Assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result strobe while sequencer busy");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_wr_en)
      else $error("RAM write while idle");

   a_erase_ptrs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERS_RD || state_ff == ST_ERS_CMP) |-> (wr_ff <= ptr_ff))
      else $error("compaction write pointer passed read pointer");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_CMP && cmp_ge) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the store by one");

endmodule

/* tb/sv/sorted_multiset_kth_largest_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_multiset_kth_largest_top_test: self-checking bench for the k-th
// largest multiset
// Drives insert, erase, rank query and unused action commands through the
// start/busy handshake. A scoreboard class keeps its own descending copy of
// the store, predicts every answer and compares each strobed result with the
// oldest prediction. A short directed opening covers the special cases. Random
// traffic then alternates between filling the store to capacity and draining
// it again.
// ----------------------------------------------------------------------------
module sorted_multiset_kth_largest_top_test;
   import smk_pkg::*;

   localparam int unsigned STORE_DEPTH   = 256;
   localparam int unsigned RANDOM_ITEMS  = 1275;
   localparam int unsigned STEADY_TAIL   = 150;
   localparam logic [ACTION_W-1:0] ACTION_UNUSED = 2'd3;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [KEY_W-1:0] value;
      status_type              status;
      int unsigned             serial;
   } rank_answer_type;

   // Scoreboard: mirrors the store in descending order and queues the
   // answer each accepted command must produce.
   class kth_largest_checker;
      logic signed [KEY_W-1:0] held_desc[$];
      rank_answer_type         answers_due[$];
      int unsigned             accepted;
      int unsigned             mismatches;

      task report_mismatch(input string msg);
         if (mismatches < 100) begin
            $display("MISMATCH: %s", msg);
         end
         mismatches++;
      endtask

      function void note_request(input logic [ACTION_W-1:0] act,
                                 input logic signed [KEY_W-1:0] key,
                                 input logic [RANK_W-1:0] rnk);
         rank_answer_type due;
         int unsigned     pos;
         due.value  = '0;
         due.status = STAT_OK;
         due.serial = accepted;
         accepted++;
         case (act)
            ACT_INSERT: begin
               if (held_desc.size() >= STORE_DEPTH) begin
                  due.status = STAT_FULL;
               end else begin
                  // new copy lands after any equal copies
                  pos = 0;
                  while (pos < held_desc.size() && held_desc[pos] >= key) pos++;
                  held_desc.insert(pos, key);
               end
            end
            ACT_ERASE: begin
               for (int i = held_desc.size() - 1; i >= 0; i--) begin
                  if (held_desc[i] == key) held_desc.delete(i);
               end
            end
            ACT_QUERY: begin
               if (rnk == 0 || rnk > held_desc.size()) begin
                  due.status = STAT_RANK;
               end else begin
                  due.value = held_desc[rnk - 1];
               end
            end
            default: begin
            end
         endcase
         answers_due.push_back(due);
      endfunction

      task check_answer(input logic signed [KEY_W-1:0] value,
                        input logic [STATUS_W-1:0] status);
         rank_answer_type due;
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: value %0d status %0d",
                                      value, status));
         end else begin
            due = answers_due.pop_front();
            if (value !== due.value) begin
               report_mismatch($sformatf("item %0d: result_value %0d, predicted %0d",
                                         due.serial, value, due.value));
            end
            if (status !== due.status) begin
               report_mismatch($sformatf("item %0d: status %0d, predicted %0d",
                                         due.serial, status, due.status));
            end
         end
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [ACTION_W-1:0]     req_action = '0;
   logic signed [KEY_W-1:0] req_key_value = '0;
   logic [RANK_W-1:0]       req_rank = '0;
   logic                    rsp_valid;
   logic signed [KEY_W-1:0] rsp_result_value;
   logic [STATUS_W-1:0]     rsp_status;

   kth_largest_checker sb = new;

   sorted_multiset_kth_largest_top #(
      .CAPACITY(STORE_DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key_value   (req_key_value),
      .req_rank        (req_rank),
      .rsp_valid       (rsp_valid),
      .rsp_result_value(rsp_result_value),
      .rsp_status      (rsp_status)
   );

   always #5 clock = ~clock;

   // Results cannot be held off: sample the strobe at every rising edge.
   // Values read here are the ones present before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_answer(rsp_result_value, rsp_status);
      end
   end

   // Present one command and hold it until the block takes it. The caller
   // sits on a rising edge; start stays high if another command follows,
   // so it is never lowered and raised in the same step.
   task automatic send_item(input logic [ACTION_W-1:0] act,
                            input logic signed [KEY_W-1:0] key,
                            input logic [RANK_W-1:0] rnk);
      start         <= 1'b1;
      req_action    <= act;
      req_key_value <= key;
      req_rank      <= rnk;
      @(posedge clock);
      // busy read here is its value before this edge: the transfer
      // happens at the first edge that finds it low
      while (busy) @(posedge clock);
      sb.note_request(act, key, rnk);
   endtask

   // Drop start for a burst of idle cycles.
   task automatic idle_for(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Key mix: a narrow pool that builds up duplicates, full-width values,
   // the signed extremes, or a value already held when asked for.
   function automatic logic signed [KEY_W-1:0] pick_key(input bit from_held);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (from_held && sb.held_desc.size() != 0) begin
         return sb.held_desc[$urandom_range(0, sb.held_desc.size() - 1)];
      end
      if (sel < 4) return int'($urandom_range(0, 8)) - 4;
      if (sel < 8) return $urandom;
      case ($urandom_range(0, 3))
         0:       return KEY_MAX;
         1:       return KEY_MIN;
         2:       return '0;
         default: return -1;
      endcase
   endfunction

   // Mostly legal ranks, plus zero, one past the count, the store depth and any value of the full field.
   function automatic logic [RANK_W-1:0] pick_rank(input int unsigned count);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 6 && count != 0) return RANK_W'($urandom_range(1, count));
      if (sel == 6) return '0;
      if (sel == 7) return RANK_W'(count + 1);
      if (sel == 8) return RANK_W'(STORE_DEPTH);
      return RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
   endfunction

   initial begin
      logic [ACTION_W-1:0]     act;
      logic signed [KEY_W-1:0] key;
      logic [RANK_W-1:0]       rnk;
      int unsigned             count;
      int unsigned             roll;
      int unsigned             full_streak;
      bit                      filling;
      bit                      calm;

      // hold reset, then release on an edge
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty store, extremes, duplicates, every action.
      send_item(ACT_QUERY, '0, 9'd1);            // rank on an empty store
      send_item(ACT_QUERY, '0, 9'd0);            // rank zero
      send_item(ACT_ERASE, 32'sd5, '0);          // erase of an absent value
      send_item(ACTION_UNUSED, -1, '1);          // unused action: answered, store unchanged
      send_item(ACT_INSERT, KEY_MAX, '0);
      send_item(ACT_INSERT, KEY_MIN, '0);
      send_item(ACT_INSERT, '0, '0);
      send_item(ACT_INSERT, -1, '0);
      send_item(ACT_INSERT, '0, '0);             // duplicate
      send_item(ACT_INSERT, 32'sd1, '0);
      for (int r = 1; r <= 6; r++) begin
         send_item(ACT_QUERY, '0, RANK_W'(r));
      end
      send_item(ACT_QUERY, '0, 9'd7);            // one past the count
      send_item(ACT_QUERY, '0, '1);              // widest rank
      send_item(ACT_QUERY, '0, RANK_W'(STORE_DEPTH));
      send_item(ACT_ERASE, '0, '0);              // drop both zero copies
      send_item(ACT_QUERY, '0, 9'd3);
      send_item(ACT_ERASE, KEY_MIN, '0);
      send_item(ACT_QUERY, '0, 9'd3);
      send_item(ACT_ERASE, KEY_MAX, '0);
      send_item(ACTION_UNUSED, '1, '0);

      // Random traffic. Fill toward capacity (and linger there so inserts
      // bounce off the full store), then drain mostly by erasing held
      // values until the store is nearly empty, and repeat.
      filling     = 1'b1;
      full_streak = 0;
      calm        = 1'b0;
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         count = sb.held_desc.size();
         if (filling && count == STORE_DEPTH) full_streak++;
         if (filling && full_streak > 20) begin
            filling     = 1'b0;
            full_streak = 0;
         end else if (!filling && count < 16) begin
            filling = 1'b1;
         end

         roll = $urandom_range(0, 99);
         rnk  = RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
         if (roll < 5) begin
            act = ACTION_UNUSED;
            key = $urandom;
         end else if (roll < (filling ? 65 : 25)) begin
            act = ACT_INSERT;
            key = pick_key($urandom_range(0, 9) == 0);
         end else if (roll < (filling ? 78 : 65)) begin
            act = ACT_ERASE;
            // while filling, erase mostly misses; while draining it hits
            key = pick_key(filling ? ($urandom_range(0, 4) == 0)
                                   : ($urandom_range(0, 3) != 0));
         end else begin
            act = ACT_QUERY;
            key = $urandom;
            rnk = pick_rank(count);
         end
         send_item(act, key, rnk);

         // idle bursts, with calm stretches; none in the closing part
         if (n + STEADY_TAIL < RANDOM_ITEMS) begin
            if (n % 60 == 0) calm = ($urandom_range(0, 2) == 0);
            if (!calm && $urandom_range(0, 2) == 0) idle_for($urandom_range(1, 7));
         end
      end
      start <= 1'b0;

      // drain outstanding answers, then watch for stray strobes
      while (sb.answers_due.size() != 0) @(posedge clock);
      repeat (2 * STORE_DEPTH + 8) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #50_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
rtl/smk_pkg.sv
rtl/smk_ram.sv
rtl/sorted_multiset_kth_largest_top.sv
tb/sv/sorted_multiset_kth_largest_top_test.sv
